// ===== hw/rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_cell and lru_key_value_cache; depends on nothing.
package lkvc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_STORE  = 1'b1;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_FILL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     use_lru;
        logic     write;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache: request capture,
// sequencer, capacity register, hit collection and result register.
// Depends on lkvc_pkg and lkvc_cell.
//
//   Channel  Direction  Handshake              Contents
//   s_       in         s_valid / s_ready      s_req_type, s_key, s_value
//   m_       out        m_valid / m_ready      m_hit, m_read_value
//   cfg_     in         cfg_valid / cfg_ready  cfg_cache_capacity
//
// Each request passes through the accepting state, a compare state in which
// every cell compares its key in parallel, and an update state in which the
// cells adjust their ranks and the lookup result is loaded.
// A lookup result waits in the update state while the output register is full.
// Reset is synchronous and active low; it empties every entry at once.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  s_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] m_read_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]         cfg_cache_capacity
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

    lkvc_pkg::state_t             state_reg, state_next;
    logic                         req_type_reg;
    logic [lkvc_pkg::KEY_W-1:0]   req_key_reg;
    logic [lkvc_pkg::DATA_W-1:0]  req_data_reg;
    logic [lkvc_pkg::CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]             occ_reg, occ_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_hit_reg, m_hit_next;
    logic [lkvc_pkg::DATA_W-1:0]  m_data_reg, m_data_next;

    logic [ENTRIES-1:0]           cell_valid;
    logic [ENTRIES-1:0]           cell_match;
    logic [lkvc_pkg::DATA_W-1:0]  cell_data [ENTRIES];
    logic [RANK_W-1:0]            cell_rank [ENTRIES];

    lkvc_pkg::cell_cmd_t          cmd;
    logic                         cmp_en;
    logic [RANK_W-1:0]            ref_rank;
    logic [RANK_W-1:0]            lru_rank;
    logic [OCC_W-1:0]             occ_m1;
    logic [CMP_W-1:0]             cap_eff;
    logic                         hit_any;
    logic [lkvc_pkg::DATA_W-1:0]  hit_data;
    logic [RANK_W-1:0]            hit_rank;
    logic                         out_free;
    logic                         s_accept;

    assign s_ready   = (state_reg == lkvc_pkg::ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign occ_m1    = occ_reg - OCC_W'(1);
    assign lru_rank  = occ_m1[RANK_W-1:0];

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    // Valid keys are unique, so at most one cell matches and an OR gathers it.
    always_comb begin
        hit_any  = 1'b0;
        hit_data = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_any  = hit_any | cell_match[i];
            hit_data = hit_data | ({lkvc_pkg::DATA_W{cell_match[i]}} & cell_data[i]);
            hit_rank = hit_rank | ({RANK_W{cell_match[i]}} & cell_rank[i]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic prev_valid;
            if (g == 0) begin : g_head
                assign prev_valid = 1'b1;
            end else begin : g_link
                assign prev_valid = cell_valid[g-1];
            end
            lkvc_cell #(
                .RANK_W (RANK_W)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .prev_valid_i (prev_valid),
                .cmp_en_i     (cmp_en),
                .req_key_i    (req_key_reg),
                .req_data_i   (req_data_reg),
                .cmd_i        (cmd),
                .ref_rank_i   (ref_rank),
                .lru_rank_i   (lru_rank),
                .valid_o      (cell_valid[g]),
                .match_o      (cell_match[g]),
                .data_o       (cell_data[g]),
                .rank_o       (cell_rank[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lkvc_pkg::ST_IDLE;
            cap_reg     <= lkvc_pkg::CAP_RESET;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_cache_capacity;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_type_reg <= s_req_type;
            req_key_reg  <= s_key;
            req_data_reg <= s_value;
        end
        m_hit_reg  <= m_hit_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_next   = m_hit_reg;
        m_data_next  = m_data_reg;
        cmp_en       = 1'b0;
        cmd.op       = lkvc_pkg::OP_NONE;
        cmd.use_lru  = 1'b0;
        cmd.write    = 1'b0;
        ref_rank     = hit_rank;
        case (state_reg)
            lkvc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = lkvc_pkg::ST_CMP;
                end
            end
            lkvc_pkg::ST_CMP: begin
                cmp_en     = 1'b1;
                state_next = lkvc_pkg::ST_UPD;
            end
            lkvc_pkg::ST_UPD: begin
                if (req_type_reg == lkvc_pkg::REQ_LOOKUP) begin
                    if (out_free) begin
                        state_next   = lkvc_pkg::ST_IDLE;
                        m_valid_next = 1'b1;
                        m_hit_next   = hit_any;
                        m_data_next  = hit_any ? hit_data : lkvc_pkg::MISS_VALUE;
                        if (hit_any) begin
                            cmd.op = lkvc_pkg::OP_TOUCH;
                        end
                    end
                end else begin
                    state_next = lkvc_pkg::ST_IDLE;
                    if (hit_any) begin
                        cmd.op    = lkvc_pkg::OP_TOUCH;
                        cmd.write = 1'b1;
                    end else if (CMP_W'(occ_reg) < cap_eff) begin
                        cmd.op   = lkvc_pkg::OP_FILL;
                        occ_next = occ_reg + OCC_W'(1);
                    end else begin
                        cmd.op      = lkvc_pkg::OP_TOUCH;
                        cmd.use_lru = 1'b1;
                        cmd.write   = 1'b1;
                        ref_rank    = lru_rank;
                    end
                end
            end
            default: begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_data_reg;

endmodule

// ===== hw/rtl/lkvc_cell.sv =====
// One cache entry: valid mark, key, data, recency rank and key compare.
// Depends on lkvc_pkg for the command struct and field widths.
module lkvc_cell #(
    parameter int RANK_W = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         prev_valid_i,
    input  logic                         cmp_en_i,
    input  logic [lkvc_pkg::KEY_W-1:0]   req_key_i,
    input  logic [lkvc_pkg::DATA_W-1:0]  req_data_i,
    input  lkvc_pkg::cell_cmd_t          cmd_i,
    input  logic [RANK_W-1:0]            ref_rank_i,
    input  logic [RANK_W-1:0]            lru_rank_i,
    output logic                         valid_o,
    output logic                         match_o,
    output logic [lkvc_pkg::DATA_W-1:0]  data_o,
    output logic [RANK_W-1:0]            rank_o
);

    logic                        valid_reg;
    logic                        match_reg;
    logic [RANK_W-1:0]           rank_reg;
    logic [lkvc_pkg::KEY_W-1:0]  key_reg;
    logic [lkvc_pkg::DATA_W-1:0] data_reg;
    logic                        target;
    logic                        is_free;
    logic                        load;

    // Entries never leave the valid state, so the valid cells form a prefix
    // of the chain and the first free cell follows the last valid one.
    assign is_free = !valid_reg && prev_valid_i;
    assign target  = cmd_i.use_lru ? (valid_reg && (rank_reg == lru_rank_i)) : match_reg;
    assign load    = ((cmd_i.op == lkvc_pkg::OP_TOUCH) && target && cmd_i.write)
                   || ((cmd_i.op == lkvc_pkg::OP_FILL) && is_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            if (cmp_en_i) begin
                match_reg <= valid_reg && (key_reg == req_key_i);
            end
            case (cmd_i.op)
                lkvc_pkg::OP_TOUCH: begin
                    if (target) begin
                        rank_reg <= '0;
                    end else if (valid_reg && (rank_reg < ref_rank_i)) begin
                        rank_reg <= rank_reg + RANK_W'(1);
                    end
                end
                lkvc_pkg::OP_FILL: begin
                    if (valid_reg) begin
                        rank_reg <= rank_reg + RANK_W'(1);
                    end else if (is_free) begin
                        valid_reg <= 1'b1;
                        rank_reg  <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            key_reg  <= req_key_i;
            data_reg <= req_data_i;
        end
    end

    assign valid_o = valid_reg;
    assign match_o = match_reg;
    assign data_o  = data_reg;
    assign rank_o  = rank_reg;

endmodule
